// ===== hw/rtl/anpr_pkg.sv =====
// anpr_pkg: types, opcode masks and status codes for the AArch64 next-PC resolver.
// No dependencies; imported by every module of the block.
package anpr_pkg;

  localparam int unsigned PcW   = 64;
  localparam int unsigned InsnW = 32;
  localparam int unsigned FlagW = 4;
  localparam int unsigned RegW  = 64;

  localparam int unsigned InDataW  = 168;  // pc, insn, nzcv, reg_value, zero pad
  localparam int unsigned OutDataW = 72;   // next_pc, taken, zero pad

  localparam logic [InsnW-1:0] MASK_B    = 32'hFC00_0000;
  localparam logic [InsnW-1:0] OP_B      = 32'h1400_0000;
  localparam logic [InsnW-1:0] OP_BL     = 32'h9400_0000;
  localparam logic [InsnW-1:0] MASK_BCC  = 32'hFF00_0000;
  localparam logic [InsnW-1:0] OP_BCC    = 32'h5400_0000;
  localparam logic [InsnW-1:0] MASK_CMPT = 32'h7E00_0000;
  localparam logic [InsnW-1:0] OP_CB     = 32'h3400_0000;
  localparam logic [InsnW-1:0] OP_TB     = 32'h3600_0000;
  localparam logic [InsnW-1:0] MASK_BR   = 32'hFFFF_FC1F;
  localparam logic [InsnW-1:0] OP_BR     = 32'hD61F_0000;
  localparam logic [InsnW-1:0] OP_BLR    = 32'hD63F_0000;
  localparam logic [InsnW-1:0] OP_RET    = 32'hD65F_0000;
  localparam logic [InsnW-1:0] MASK_BRG  = 32'hFE00_0000;
  localparam logic [InsnW-1:0] OP_BRG    = 32'hD600_0000;
  localparam logic [InsnW-1:0] MASK_OP2  = 32'h001F_0000;

  localparam logic [4:0] REG_ZR = 5'd31;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEC = 2'd1,
    ST_FAULT = 2'd2
  } status_t;

  typedef struct packed {
    logic [RegW-1:0]  reg_value;
    logic [FlagW-1:0] nzcv;
    logic             fetch_fault;
    logic [InsnW-1:0] insn;
    logic [PcW-1:0]   pc;
  } in_item_t;

  typedef struct packed {
    status_t        status;
    logic           taken;
    logic [PcW-1:0] next_pc;
  } res_t;

endpackage

// ===== hw/rtl/anpr_decode.sv =====
// anpr_decode: combinational branch decode, condition check and target add.
// Depends on anpr_pkg.
module anpr_decode
  import anpr_pkg::*;
(
  input  in_item_t item,
  output res_t     res
);

  logic [InsnW-1:0] w;
  logic             is_b;
  logic             is_bcc;
  logic             is_cb;
  logic             is_tb;
  logic             is_br;
  logic             is_undec;
  logic             cond_ok;
  logic             cond_raw;
  logic [RegW-1:0]  rt_val;
  logic [RegW-1:0]  rn_val;
  logic [RegW-1:0]  cb_val;
  logic [5:0]       bitno;
  logic             cb_hit;
  logic             tb_hit;
  logic [PcW-1:0]   off_b;
  logic [PcW-1:0]   off_19;
  logic [PcW-1:0]   off_14;
  logic [PcW-1:0]   offset;
  logic [PcW-1:0]   sum;
  status_t          status_c;
  logic             taken_c;
  logic             n_f;
  logic             z_f;
  logic             c_f;
  logic             v_f;

  assign w   = item.insn;
  assign n_f = item.nzcv[3];
  assign z_f = item.nzcv[2];
  assign c_f = item.nzcv[1];
  assign v_f = item.nzcv[0];

  assign is_b     = ((w & MASK_B) == OP_B) || ((w & MASK_B) == OP_BL);
  assign is_bcc   = (w & MASK_BCC) == OP_BCC;
  assign is_cb    = (w & MASK_CMPT) == OP_CB;
  assign is_tb    = (w & MASK_CMPT) == OP_TB;
  assign is_br    = ((w & MASK_BR) == OP_BR) || ((w & MASK_BR) == OP_BLR)
                 || ((w & MASK_BR) == OP_RET);
  assign is_undec = ((w & MASK_BRG) == OP_BRG) && ((w & MASK_OP2) != '0);

  always_comb begin
    case (w[3:1])
      3'd0:    cond_raw = z_f;
      3'd1:    cond_raw = c_f;
      3'd2:    cond_raw = n_f;
      3'd3:    cond_raw = v_f;
      3'd4:    cond_raw = c_f && !z_f;
      3'd5:    cond_raw = (n_f == v_f);
      3'd6:    cond_raw = !z_f && (n_f == v_f);
      default: cond_raw = 1'b1;
    endcase
  end

  // odd codes invert, except NV which is always true
  assign cond_ok = (w[0] && (w[3:0] != 4'hF)) ? !cond_raw : cond_raw;

  assign rt_val = (w[4:0] == REG_ZR) ? '0 : item.reg_value;
  assign rn_val = (w[9:5] == REG_ZR) ? '0 : item.reg_value;
  assign cb_val = w[31] ? rt_val : {32'd0, rt_val[31:0]};
  assign cb_hit = w[24] ? (cb_val != '0) : (cb_val == '0);
  assign bitno  = {w[31], w[23:19]};
  assign tb_hit = w[24] ? rt_val[bitno] : !rt_val[bitno];

  assign off_b  = {{36{w[25]}}, w[25:0], 2'b00};
  assign off_19 = {{43{w[23]}}, w[23:5], 2'b00};
  assign off_14 = {{48{w[18]}}, w[18:5], 2'b00};

  always_comb begin
    status_c = ST_OK;
    taken_c  = 1'b0;
    offset   = 64'd4;
    if (item.fetch_fault) begin
      status_c = ST_FAULT;
    end else if (is_b) begin
      offset  = off_b;
      taken_c = 1'b1;
    end else if (is_bcc) begin
      if (cond_ok) begin
        offset  = off_19;
        taken_c = 1'b1;
      end
    end else if (is_cb) begin
      if (cb_hit) begin
        offset  = off_19;
        taken_c = 1'b1;
      end
    end else if (is_tb) begin
      if (tb_hit) begin
        offset  = off_14;
        taken_c = 1'b1;
      end
    end else if (is_br) begin
      taken_c = 1'b1;
    end else if (is_undec) begin
      status_c = ST_UNDEC;
    end
  end

  assign sum = item.pc + offset;

  always_comb begin
    res.status  = status_c;
    res.taken   = taken_c;
    res.next_pc = sum;
    if (status_c != ST_OK) begin
      res.next_pc = '0;
    end else if (is_br) begin
      res.next_pc = rn_val;
    end
  end

endmodule

// ===== hw/rtl/aarch64_next_pc_resolver_top.sv =====
// aarch64_next_pc_resolver_top: input register, branch decode, result register.
// Depends on anpr_pkg and anpr_decode.
//
//  channel | dir | tdata                                  | tuser
//  in_     | in  | pc, insn, nzcv, reg_value (168 bits)   | fetch_fault
//  out_    | out | next_pc, taken (72 bits)               | status
//
// One transfer per cycle sustained while the sink keeps out_tready high.
// The decode and one 64-bit adder sit between the two registers.
// Synchronous active-low reset empties both stages.
// A stalled result holds; the input register still takes a transfer while it is empty.
module aarch64_next_pc_resolver_top
  import anpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [63:0] pc, [95:64] insn, [99:96] nzcv,
                                          // [163:100] reg_value, [167:164] zero
  input  logic                in_tuser,   // [0] fetch_fault
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [63:0] next_pc, [64] taken, [71:65] zero
  output logic [1:0]          out_tuser   // [1:0] status
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  res_t     out_res_r;
  res_t     dec_res;
  logic     adv;
  logic     in_xfer;
  in_item_t in_item;

  assign in_item = '{reg_value:   in_tdata[163:100],
                     nzcv:        in_tdata[99:96],
                     fetch_fault: in_tuser,
                     insn:        in_tdata[95:64],
                     pc:          in_tdata[63:0]};

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv || !s1_valid_r;
  assign in_xfer   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  anpr_decode u_decode (
    .item (s1_item_r),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (adv && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.taken, out_res_r.next_pc};
  assign out_tuser  = out_res_r.status;

endmodule

// ===== hw/rtl/anpr_checker.sv =====
// anpr_checker: port-level assertions for the next-PC resolver, bound to the top level.
// Depends on anpr_pkg.
module anpr_checker
  import anpr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [InDataW-1:0]  in_tdata,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic [1:0]          out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[63:0] == '0) && !out_tdata[64])
    else $error("non-ok status with nonzero next_pc or taken");

  // fault transfer followed by a draining sink passes the input register into the result register
  a_fault_passes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser ##1 out_tready
    |=> out_tvalid && (out_tuser == ST_FAULT))
    else $error("fetch fault not reported");

endmodule

bind aarch64_next_pc_resolver_top anpr_checker u_anpr_checker (.*);

// ===== tb/next_pc_checker.sv =====
// next_pc_checker: watches both stream channels of the next-PC resolver, predicts
// next_pc, taken and status for every input transfer and compares them in order.
// Depends on anpr_pkg for field widths, opcode masks and status codes.
module next_pc_checker
  import anpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic [1:0]          out_tuser,
  output int unsigned         outstanding,
  output int unsigned         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    CP_EQ, CP_CS, CP_MI, CP_VS, CP_HI, CP_GE, CP_GT, CP_AL
  } cond_pair_t;

  localparam logic [3:0] COND_NV = 4'hF;

  res_t        expected_results[$];
  int unsigned err_count = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic logic cond_passes(input logic [3:0] cc, input logic [3:0] f);
    logic n, z, c, v, r;
    n = f[3];
    z = f[2];
    c = f[1];
    v = f[0];
    case (cond_pair_t'(cc[3:1]))
      CP_EQ:   r = z;
      CP_CS:   r = c;
      CP_MI:   r = n;
      CP_VS:   r = v;
      CP_HI:   r = c && !z;
      CP_GE:   r = (n == v);
      CP_GT:   r = !z && (n == v);
      default: r = 1'b1;
    endcase
    // odd codes invert, except NV which behaves like AL
    if (cc[0] && cc != COND_NV) r = !r;
    return r;
  endfunction

  function automatic res_t resolve_next_pc(input logic [PcW-1:0] pc,
                                           input logic [InsnW-1:0] w,
                                           input logic fault,
                                           input logic [FlagW-1:0] nzcv,
                                           input logic [RegW-1:0] rv);
    res_t          r;
    logic [63:0]   v;
    logic [5:0]    bitno;
    logic          hit;
    r.next_pc = pc + 64'd4;
    r.taken   = 1'b0;
    r.status  = ST_OK;
    v         = (w[4:0] == REG_ZR) ? '0 : rv;
    if (fault) begin
      r.next_pc = '0;
      r.status  = ST_FAULT;
    end else if ((w & MASK_B) == OP_B || (w & MASK_B) == OP_BL) begin
      r.next_pc = pc + {{36{w[25]}}, w[25:0], 2'b00};
      r.taken   = 1'b1;
    end else if ((w & MASK_BCC) == OP_BCC) begin
      if (cond_passes(w[3:0], nzcv)) begin
        r.next_pc = pc + {{43{w[23]}}, w[23:5], 2'b00};
        r.taken   = 1'b1;
      end
    end else if ((w & MASK_CMPT) == OP_CB) begin
      if (!w[31]) v[63:32] = '0;
      hit = w[24] ? (v != '0) : (v == '0);
      if (hit) begin
        r.next_pc = pc + {{43{w[23]}}, w[23:5], 2'b00};
        r.taken   = 1'b1;
      end
    end else if ((w & MASK_CMPT) == OP_TB) begin
      bitno = {w[31], w[23:19]};
      hit   = w[24] ? v[bitno] : !v[bitno];
      if (hit) begin
        r.next_pc = pc + {{48{w[18]}}, w[18:5], 2'b00};
        r.taken   = 1'b1;
      end
    end else if ((w & MASK_BR) == OP_BR || (w & MASK_BR) == OP_BLR ||
                 (w & MASK_BR) == OP_RET) begin
      r.next_pc = (w[9:5] == REG_ZR) ? '0 : rv;
      r.taken   = 1'b1;
    end else if ((w & MASK_BRG) == OP_BRG && (w & MASK_OP2) != '0) begin
      r.next_pc = '0;
      r.status  = ST_UNDEC;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer next_pc %h taken %b status %0d",
                   $time, out_tdata[63:0], out_tdata[64], out_tuser);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[63:0] !== want.next_pc) begin
            $display("%0t: next_pc expected %h actual %h",
                     $time, want.next_pc, out_tdata[63:0]);
            err_count++;
          end
          if (out_tdata[64] !== want.taken) begin
            $display("%0t: taken expected %b actual %b", $time, want.taken, out_tdata[64]);
            err_count++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(resolve_next_pc(in_tdata[63:0], in_tdata[95:64], in_tuser,
                                                   in_tdata[99:96], in_tdata[163:100]));
    end
    outstanding <= expected_results.size();
    mismatches  <= err_count;
  end

endmodule

// ===== tb/tb.sv =====
// tb: top of the next-PC resolver testbench; clock, reset, bursty instruction stimulus
// and a stalling result sink. Depends on anpr_pkg, aarch64_next_pc_resolver_top and
// next_pc_checker, which does all prediction and comparison.
module tb
  import anpr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [1:0]          out_tuser;
  int unsigned         outstanding;
  int unsigned         mismatches;

  aarch64_next_pc_resolver_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  next_pc_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic offer(input logic [63:0] pc, input logic [31:0] insn, input logic fault,
                       input logic [3:0] nzcv, input logic [63:0] rv);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, rv, nzcv, insn, pc};
    in_tuser  <= fault;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(7) == 0) ? REG_ZR : 5'($urandom_range(31));
  endfunction

  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return {$urandom, $urandom};
      1:       return 64'd1 << $urandom_range(63);
      2:       return {$urandom, 32'b0};
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [31:0] pick_insn();
    logic [2:0] pick;
    case ($urandom_range(15))
      0, 1, 2:
        return ($urandom_range(1) ? OP_BL : OP_B) | {6'b0, 26'($urandom)};
      3, 4, 5:
        return OP_BCC | {8'b0, 19'($urandom), 1'($urandom), 4'($urandom)};
      6, 7, 8:
        return OP_CB | {1'($urandom), 6'b0, 1'($urandom), 19'($urandom), pick_reg()};
      9, 10, 11:
        return OP_TB | {1'($urandom), 6'b0, 1'($urandom), 5'($urandom), 14'($urandom),
                        pick_reg()};
      12, 13: begin
        pick = 3'($urandom_range(2));
        return (pick == 0 ? OP_BR : pick == 1 ? OP_BLR : OP_RET) |
               {22'b0, pick_reg(), 5'b0};
      end
      14:      return OP_BRG | {7'b0, 25'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    logic [63:0] pc;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    rst_n     = 1'b0;
    sent      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fetch fault overrides a valid branch
    offer('1, OP_BL, 1'b1, 4'hF, '1);
    // B/BL offset extremes, wrapping both ways
    offer('0, OP_B | {6'b0, 26'h3FF_FFFF}, 1'b0, 4'h0, '0);
    offer(64'h100, OP_BL | {6'b0, 26'h200_0000}, 1'b0, 4'h0, '0);
    offer('1, OP_B | {6'b0, 26'h1FF_FFFF}, 1'b0, 4'h0, '0);
    for (int c = 0; c < 16; c++)
      offer({$urandom, $urandom}, OP_BCC | {8'b0, c[0] ? 19'h4_0000 : 19'h3_FFFF, 1'b0, c[3:0]},
            1'b0, 4'($urandom), '0);
    // CBZ 32-bit ignores the upper half
    offer(64'h8000, OP_CB | {1'b0, 6'b0, 1'b0, 19'h10, 5'd3}, 1'b0, 4'h0,
          64'hFFFF_FFFF_0000_0000);
    // CBNZ on the zero register
    offer(64'h8000, OP_CB | {1'b1, 6'b0, 1'b1, 19'h7_FFF0, REG_ZR}, 1'b0, 4'h0, '1);
    // TBNZ bit 63
    offer(64'h4000, OP_TB | {1'b1, 6'b0, 1'b1, 5'h1F, 14'h2000, 5'd0}, 1'b0, 4'h0,
          64'h8000_0000_0000_0000);
    offer(64'h4000, OP_BR | {22'b0, REG_ZR, 5'b0}, 1'b0, 4'h0, '1);
    offer(64'h4000, 32'hD69F_03E0, 1'b0, 4'h0, '1);  // ERET: undecodable
    offer(64'h4000, OP_BRG | 32'h0000_03E0, 1'b0, 4'h0, '1);

    while (sent < 1500) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        pc = ($urandom_range(7) == 0) ? ~64'($urandom_range(255)) : {$urandom, $urandom};
        offer(pc, pick_insn(), $urandom_range(15) == 0, 4'($urandom), pick_reg_value());
        sent++;
      end
      idle_for(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned stretch;
    int unsigned mode;
    int unsigned hold;
    out_tready = 1'b0;
    stretch    = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (stretch == 4) begin
        // long back-pressure while the sender keeps offering
        out_tready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
      end else begin
        mode = $urandom_range(3);
        repeat ($urandom_range(10, 80)) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom);
            2:       out_tready <= ($urandom_range(3) == 0);
            default: out_tready <= ($urandom_range(7) != 0);
          endcase
          @(posedge clk);
        end
      end
      stretch++;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/anpr_pkg.sv
hw/rtl/anpr_decode.sv
hw/rtl/aarch64_next_pc_resolver_top.sv
hw/rtl/anpr_checker.sv
tb/next_pc_checker.sv
tb/tb.sv
